// File: rtl/asbs_pkg.sv
`timescale 1ns / 1ps

package asbs_pkg;

	// Flight mode carried by each request. Codes five to seven are unused.
	typedef enum logic [2:0] {
		MODE_STANDBY = 3'd0,
		MODE_ASCENT  = 3'd1,
		MODE_DESCENT = 3'd2,
		MODE_SAFE    = 3'd3,
		MODE_MANUAL  = 3'd4
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FLUSH_SECONDS = 3'd0,
		REG_FILL_BAG1     = 3'd1,
		REG_FILL_BAG6     = 3'd6
	} reg_index_t;

	localparam int unsigned BAG_COUNT  = 6;
	localparam int unsigned VALVE_BITS = 6;
	// The highest bag that can really be served: it needs a valve and a fill time.
	localparam int unsigned LAST_BAG   = (BAG_COUNT < VALVE_BITS) ? BAG_COUNT : VALVE_BITS;

	localparam int unsigned SECONDS_W  = 17;
	localparam int unsigned CFG_W      = 8;
	localparam int unsigned BAG_W      = 3;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [SECONDS_W-1:0] PUMP_SETTLE_SECONDS = 17'd1;
	localparam logic [CFG_W-1:0]     FLUSH_SECONDS_RESET = 8'd10;
	localparam logic [CFG_W-1:0]     FILL_SECONDS_RESET  = 8'd4;
	localparam logic [BAG_W-1:0]     FIRST_BAG           = 3'd1;

endpackage

// File: rtl/air_sample_bag_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload (lowest bit first)
// s_*       in         s_tvalid/s_tready  cmd[2:0], now_seconds[19:3], in_window[20],
//                                         bag_is_ascent[21], zero fill [23:22]
// m_*       out        m_tvalid/m_tready  pump_on[0], flush_open[1], bag_valves[7:2],
//                                         intake_open[8], current_bag[11:9], zero fill
// wr_*      in         wr_en              wr_index selects the register, wr_data its value
//
// Each request is held in the input register and is applied to the sequencer
// state on the edge that moves it on; the updated state is the result, and
// m_tvalid rises with it. One request per cycle is sustained while m_tready
// allows it, set by the single compare-and-update path after the input register.
// Reset clears the valves, the pump, the intake and the valid flags and loads the
// default flush and fill times; bag one is served first.
// A stall on m_tready holds the result and the state; the input register still
// takes one more request, and s_tready falls only once that register is full too.

module air_sample_bag_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [2:0]                        wr_index,
	input  logic [7:0]                        wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cmd[2:0], now_seconds[19:3], in_window[20], bag_is_ascent[21], zeros[23:22]
	input  logic [asbs_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pump_on[0], flush_open[1], bag_valves[7:2], intake_open[8], current_bag[11:9], zeros
	output logic [asbs_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int unsigned SW = asbs_pkg::SECONDS_W;
	localparam int unsigned VB = asbs_pkg::VALVE_BITS;

	// Configuration registers.
	logic [asbs_pkg::CFG_W-1:0] flush_seconds_q;
	logic [asbs_pkg::CFG_W-1:0] fill_seconds_q [VB];

	// Input register stage.
	logic                valid_s1;
	asbs_pkg::mode_t     cmd_s1;
	logic [SW-1:0]       now_s1;
	logic                in_window_s1;
	logic                bag_is_ascent_s1;

	// Sequencer state; it is also the result that m_tdata shows.
	logic                      out_valid_q;
	logic                      pump_q, flush_q, intake_q;
	logic [VB-1:0]             valves_q;
	logic [asbs_pkg::BAG_W-1:0] bag_q;
	logic [SW-1:0]             pump_start_q, flush_start_q, bag_start_q;

	logic                      pump_d, flush_d, intake_d;
	logic [VB-1:0]             valves_d;
	logic [asbs_pkg::BAG_W-1:0] bag_d;
	logic [SW-1:0]             pump_start_d, flush_start_d, bag_start_d;

	logic                      move;
	logic                      bags_remain, do_advance, descent, bag_open;
	logic [asbs_pkg::BAG_W-1:0] idx;
	logic [VB-1:0]             bag_bit;
	logic [asbs_pkg::CFG_W-1:0] fill_sel;
	logic [SW:0]               now_ext;

	// The request in the input register is applied when the result slot is free
	// or is being emptied in this cycle.
	assign move     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, bag_q, intake_q, valves_q, flush_q, pump_q};

	// Configuration writes; an index beyond the last fill register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_seconds_q <= asbs_pkg::FLUSH_SECONDS_RESET;
			for (int i = 0; i < VB; i++) begin
				fill_seconds_q[i] <= asbs_pkg::FILL_SECONDS_RESET;
			end
		end else if (wr_en) begin
			if (wr_index == asbs_pkg::REG_FLUSH_SECONDS) begin
				flush_seconds_q <= wr_data;
			end else if (wr_index <= asbs_pkg::REG_FILL_BAG6) begin
				for (int i = 0; i < VB; i++) begin
					if (wr_index == 3'(i) + asbs_pkg::REG_FILL_BAG1) begin
						fill_seconds_q[i] <= wr_data;
					end
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1           <= asbs_pkg::mode_t'(s_tdata[2:0]);
			now_s1           <= s_tdata[19:3];
			in_window_s1     <= s_tdata[20];
			bag_is_ascent_s1 <= s_tdata[21];
		end
	end

	// Sequencer step for the request in the input register.
	always_comb begin
		pump_d        = pump_q;
		flush_d       = flush_q;
		intake_d      = intake_q;
		valves_d      = valves_q;
		bag_d         = bag_q;
		pump_start_d  = pump_start_q;
		flush_start_d = flush_start_q;
		bag_start_d   = bag_start_q;

		bags_remain = (bag_q >= asbs_pkg::FIRST_BAG) &&
			(bag_q <= asbs_pkg::BAG_W'(asbs_pkg::LAST_BAG));
		idx     = bag_q - asbs_pkg::FIRST_BAG;
		bag_bit = VB'(1) << idx;
		bag_open = |(valves_q & bag_bit);
		now_ext = {1'b0, now_s1};

		fill_sel = '0;
		for (int i = 0; i < VB; i++) begin
			if (idx == asbs_pkg::BAG_W'(i)) begin
				fill_sel = fill_seconds_q[i];
			end
		end

		descent    = 1'b0;
		do_advance = 1'b0;
		case (cmd_s1)
			asbs_pkg::MODE_ASCENT: begin
				if (bag_is_ascent_s1 && bags_remain) begin
					intake_d   = 1'b1;
					do_advance = 1'b1;
				end
			end
			asbs_pkg::MODE_DESCENT: begin
				descent    = 1'b1;
				do_advance = !bag_is_ascent_s1 && bags_remain;
			end
			asbs_pkg::MODE_SAFE: begin
				intake_d = 1'b0;
				pump_d   = 1'b0;
				valves_d = '0;
			end
			default: begin
			end
		endcase

		if (do_advance) begin
			if (!in_window_s1) begin
				// In descent a closing window ends the open bag early.
				if (descent && bag_open) begin
					valves_d = valves_q & ~bag_bit;
					pump_d   = 1'b0;
					bag_d    = bag_q + 3'd1;
				end
			end else if (bag_open) begin
				if (now_ext > {1'b0, bag_start_q} + (SW+1)'(fill_sel)) begin
					valves_d = valves_q & ~bag_bit;
					pump_d   = 1'b0;
					bag_d    = bag_q + 3'd1;
				end
			end else if (!pump_q) begin
				pump_d       = 1'b1;
				pump_start_d = now_s1;
			end else if (now_ext >
					{1'b0, pump_start_q} + {1'b0, asbs_pkg::PUMP_SETTLE_SECONDS}) begin
				if (!flush_q) begin
					flush_d       = 1'b1;
					flush_start_d = now_s1;
				end else if (now_ext > {1'b0, flush_start_q} + (SW+1)'(flush_seconds_q)) begin
					flush_d     = 1'b0;
					valves_d    = valves_q | bag_bit;
					bag_start_d = now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			pump_q        <= 1'b0;
			flush_q       <= 1'b0;
			intake_q      <= 1'b0;
			valves_q      <= '0;
			bag_q         <= asbs_pkg::FIRST_BAG;
			pump_start_q  <= '0;
			flush_start_q <= '0;
			bag_start_q   <= '0;
		end else begin
			if (move) begin
				out_valid_q   <= 1'b1;
				pump_q        <= pump_d;
				flush_q       <= flush_d;
				intake_q      <= intake_d;
				valves_q      <= valves_d;
				bag_q         <= bag_d;
				pump_start_q  <= pump_start_d;
				flush_start_q <= flush_start_d;
				bag_start_q   <= bag_start_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/asbs_checker.sv
`timescale 1ns / 1ps

module asbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the result slot empty the input side always takes a request.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with the result slot empty");

	// At most one bag valve is ever open.
	a_one_bag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[7:2]))
		else $error("more than one bag valve open");

	// The flush valve closes as the bag opens, and a bag only fills with the pump running.
	a_valves: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[7:2] != 6'd0) |-> !m_tdata[1] && m_tdata[0])
		else $error("bag open with flush open or pump off");

	// The bag number never reads zero.
	a_bag_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:9] != 3'd0)
		else $error("bag number out of range");

endmodule

bind air_sample_bag_sequencer asbs_checker u_asbs_checker (.*);

// File: tb/air_sample_bag_sequencer_tb.sv
`timescale 1ns / 1ps

module air_sample_bag_sequencer_tb;

	// Mode codes five to seven are not named in the package. The block must ignore them.
	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
	// Register index seven selects nothing. Writes to it must be dropped.
	localparam logic [2:0] REG_SPARE        = 3'd7;

	localparam int unsigned DAY_LAST      = 86399;
	localparam int unsigned SEGMENTS      = 7;
	localparam int unsigned SEG_REQS      = 90;
	// Roughly how many requests one bag should take, so that the six bags
	// (they can only be used once per reset) last for the whole run.
	localparam int unsigned BAG_PACE      = 150;
	// Each request passes the input register and then the sequencer state. This pause adds some margin.
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned MAX_REPORTS   = 10;

	// Request fields, with the last field in the lowest bits as on s_tdata.
	typedef struct packed {
		logic        asc_bag;
		logic        window;
		logic [16:0] now;
		logic [2:0]  cmd;
	} sample_req_t;

	// Result fields, packed in the same order as m_tdata so that a plain copy unpacks it.
	typedef struct packed {
		logic [3:0] pad;
		logic [2:0] bag;
		logic       intake;
		logic [5:0] valves;
		logic       flush;
		logic       pump;
	} valve_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [7:0]  wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	air_sample_bag_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the configuration registers, updated as they are written.
	logic [7:0] flush_cfg;
	logic [7:0] fill_cfg [asbs_pkg::VALVE_BITS];

	// Predicted sequencer state. Times are kept 32 bits wide so that the
	// "more than T seconds after S" tests never wrap, just as in the block.
	logic        pump_run;
	logic        flush_run;
	logic [5:0]  valve_bits;
	logic        intake_run;
	logic [2:0]  bag_num;
	int unsigned pump_since;
	int unsigned flush_since;
	int unsigned fill_since;

	sample_req_t   pending_req [$];
	valve_status_t expected_status [$];
	sample_req_t   offered;

	logic        req_taken = 1'b0;
	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_results = 0;
	int unsigned n_fail = 0;
	int unsigned n_early_close = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned clock_sec;

	// A bag is done: its valve closes, the pump stops and the next bag is taken up.
	task automatic close_bag(input logic [5:0] mask);
		valve_bits = valve_bits & ~mask;
		pump_run   = 1'b0;
		bag_num    = bag_num + 3'd1;
	endtask

	// One step of the pump, flush and fill order for the current bag.
	task automatic advance_bag(input int unsigned now, input logic descent, input logic window);
		int unsigned idx;
		logic [5:0]  mask;
		idx  = 32'(bag_num - asbs_pkg::FIRST_BAG);
		mask = 6'd1 << idx;
		if (!window) begin
			// In descent a closing window cuts an open bag short. In ascent it only holds.
			if (descent && (valve_bits & mask) != '0) begin
				close_bag(mask);
				n_early_close++;
			end
		end else if ((valve_bits & mask) != '0) begin
			if (now > fill_since + fill_cfg[idx])
				close_bag(mask);
		end else if (!pump_run) begin
			pump_run   = 1'b1;
			pump_since = now;
		end else if (now > pump_since + asbs_pkg::PUMP_SETTLE_SECONDS) begin
			if (!flush_run) begin
				flush_run   = 1'b1;
				flush_since = now;
			end else if (now > flush_since + flush_cfg) begin
				flush_run  = 1'b0;
				valve_bits = valve_bits | mask;
				fill_since = now;
			end
		end
	endtask

	// Applies one accepted request and returns the state that the block should report.
	task automatic sequence_step(input sample_req_t r, output valve_status_t st);
		logic live;
		live = (bag_num >= asbs_pkg::FIRST_BAG) && (bag_num <= asbs_pkg::LAST_BAG);
		if (r.cmd == asbs_pkg::MODE_ASCENT) begin
			if (r.asc_bag && live) begin
				intake_run = 1'b1;
				advance_bag(32'(r.now), 1'b0, r.window);
			end
		end else if (r.cmd == asbs_pkg::MODE_DESCENT) begin
			if (!r.asc_bag && live)
				advance_bag(32'(r.now), 1'b1, r.window);
		end else if (r.cmd == asbs_pkg::MODE_SAFE) begin
			// Safe mode leaves the flush valve and the bag number alone.
			intake_run = 1'b0;
			pump_run   = 1'b0;
			valve_bits = '0;
		end
		st.pad    = '0;
		st.bag    = bag_num;
		st.intake = intake_run;
		st.valves = valve_bits;
		st.flush  = flush_run;
		st.pump   = pump_run;
	endtask

	// The driver changes inputs on the falling edge. A request that has been
	// offered stays on the bus until the rising edge that accepts it.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !req_taken)) begin
			if (pending_req.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				offered = pending_req.pop_front();
				s_tdata <= {2'b00, offered};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// The monitor samples both handshakes on the rising edge. Each accepted
	// request is predicted first. Each result is then checked against the
	// oldest prediction.
	always @(posedge clk) begin
		valve_status_t want;
		valve_status_t got;
		logic          out_taken;
		req_taken = s_tvalid && s_tready;
		out_taken = m_tvalid && m_tready;
		if (req_taken) begin
			sequence_step(offered, want);
			expected_status.push_back(want);
			n_accepted++;
		end
		if (out_taken) begin
			got = m_tdata;
			n_results++;
			if (expected_status.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected: %h", n_results, got);
			end else begin
				want = expected_status.pop_front();
				if (got !== want) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS) begin
						$display("result %0d mismatch: expected pump=%b flush=%b valves=%b intake=%b bag=%0d pad=%h",
							n_results, want.pump, want.flush, want.valves, want.intake,
							want.bag, want.pad);
						$display("    got pump=%b flush=%b valves=%b intake=%b bag=%0d pad=%h",
							got.pump, got.flush, got.valves, got.intake, got.bag, got.pad);
					end
				end
			end
		end
		// The watchdog counts cycles in which neither side moves a request or a result.
		if (req_taken || out_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_status.size());
			$display("air_sample_bag_sequencer regression: fail");
			$finish;
		end
	end

	task automatic push_req(input logic [2:0] cmd, input int unsigned now, input logic window,
			input logic asc_bag);
		sample_req_t r;
		r.cmd     = cmd;
		r.now     = now[16:0];
		r.window  = window;
		r.asc_bag = asc_bag;
		pending_req.push_back(r);
		n_queued++;
	endtask

	// Writes all registers, including the unused index. Write enable stays high
	// through the burst, so it gets only one assignment per edge.
	task automatic program_regs(input logic [7:0] flush_v, input int unsigned fill_min,
			input int unsigned fill_max);
		logic [7:0] value;
		for (int i = asbs_pkg::REG_FLUSH_SECONDS; i <= REG_SPARE; i++) begin
			if (i == asbs_pkg::REG_FLUSH_SECONDS)
				value = flush_v;
			else if (i <= asbs_pkg::REG_FILL_BAG6)
				value = 8'($urandom_range(fill_min, fill_max));
			else
				value = 8'($urandom_range(0, 255));
			@(negedge clk);
			wr_en    <= 1'b1;
			wr_index <= i[2:0];
			wr_data  <= value;
			if (i == asbs_pkg::REG_FLUSH_SECONDS)
				flush_cfg = value;
			else if (i <= asbs_pkg::REG_FILL_BAG6)
				fill_cfg[i - asbs_pkg::REG_FILL_BAG1] = value;
		end
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Holds the sender back until every queued request has been accepted and
	// every expected result has been seen, then allows the pipeline to drain.
	task automatic wait_idle;
		while (n_accepted != n_queued || expected_status.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Most requests form a well-behaved flight in one mode, with the clock
	// advancing at a rate such that a bag takes about BAG_PACE requests. The
	// remainder is noise: wrong bag flags, the opposite mode, safe mode, and
	// codes that must be ignored, carrying times across the whole day.
	task automatic queue_segment(input logic [2:0] flight);
		int unsigned span;
		int unsigned roll;
		logic [2:0]  cmd;
		logic        window;
		logic        asc_bag;
		span = flush_cfg + 8;
		if (bag_num >= asbs_pkg::FIRST_BAG && bag_num <= asbs_pkg::LAST_BAG)
			span += fill_cfg[bag_num - asbs_pkg::FIRST_BAG];
		for (int k = 0; k < SEG_REQS; k++) begin
			if (span < BAG_PACE)
				clock_sec += ($urandom_range(0, BAG_PACE - 1) < span);
			else
				clock_sec += $urandom_range(0, 2 * span / BAG_PACE);
			if (clock_sec > DAY_LAST)
				clock_sec = DAY_LAST;
			cmd     = flight;
			asc_bag = (flight == asbs_pkg::MODE_ASCENT);
			window  = ($urandom_range(0, 99) >= 3);
			roll    = $urandom_range(0, 99);
			if (roll < 6) begin
				asc_bag = !asc_bag;
			end else if (roll < 8) begin
				cmd = asbs_pkg::MODE_SAFE;
			end else if (roll < 12) begin
				cmd     = (flight == asbs_pkg::MODE_ASCENT) ? asbs_pkg::MODE_DESCENT :
					asbs_pkg::MODE_ASCENT;
				asc_bag = (cmd == asbs_pkg::MODE_ASCENT);
			end
			if (roll >= 12 && roll < 16) begin
				case ($urandom_range(0, 2))
					0:       cmd = asbs_pkg::MODE_STANDBY;
					1:       cmd = asbs_pkg::MODE_MANUAL;
					default: cmd = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
				endcase
				push_req(cmd, $urandom_range(0, DAY_LAST), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				push_req(cmd, clock_sec, window, asc_bag);
			end
		end
	endtask

	initial begin
		flush_cfg = asbs_pkg::FLUSH_SECONDS_RESET;
		for (int i = 0; i < asbs_pkg::VALVE_BITS; i++)
			fill_cfg[i] = asbs_pkg::FILL_SECONDS_RESET;
		pump_run    = 1'b0;
		flush_run   = 1'b0;
		valve_bits  = '0;
		intake_run  = 1'b0;
		bag_num     = asbs_pkg::FIRST_BAG;
		pump_since  = 0;
		flush_since = 0;
		fill_since  = 0;
		clock_sec   = 1000;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, using the reset register values (flush 10 s, fill 4 s).
		@(posedge clk);
		// Modes and flag combinations that must leave everything unchanged, with
		// time values at both ends of the day and alternating bit patterns.
		push_req(asbs_pkg::MODE_STANDBY, 0, 1'b0, 1'b0);
		push_req(asbs_pkg::MODE_MANUAL, DAY_LAST, 1'b1, 1'b1);
		push_req(MODE_SPARE_FIRST, 43690, 1'b1, 1'b0);
		push_req(MODE_SPARE_FIRST + 3'd1, 21845, 1'b0, 1'b1);
		push_req(MODE_SPARE_LAST, 65536, 1'b1, 1'b1);
		// Ascent with the window closed only opens the intake. Descent with no bag open does nothing.
		push_req(asbs_pkg::MODE_ASCENT, DAY_LAST, 1'b0, 1'b1);
		push_req(asbs_pkg::MODE_DESCENT, 0, 1'b0, 1'b0);
		push_req(asbs_pkg::MODE_SAFE, 50, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 60, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 60, 1'b1, 1'b1);
		// Bag one during ascent, with each timing edge hit exactly: the pump settles
		// only after more than one second, and the flush and the fill run only after
		// more than their configured times.
		push_req(asbs_pkg::MODE_ASCENT, 100, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 101, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 102, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 112, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 113, 1'b1, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 117, 1'b0, 1'b1);
		push_req(asbs_pkg::MODE_ASCENT, 118, 1'b1, 1'b1);
		// Bag two during descent is cut short when the window closes.
		push_req(asbs_pkg::MODE_DESCENT, 200, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 202, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 213, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 214, 1'b0, 1'b0);
		// Safe mode during the flush of bag three stops the pump, but the flush valve stays open.
		push_req(asbs_pkg::MODE_DESCENT, 300, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 302, 1'b1, 1'b0);
		push_req(asbs_pkg::MODE_SAFE, 303, 1'b0, 1'b0);
		push_req(asbs_pkg::MODE_DESCENT, 304, 1'b1, 1'b0);
		wait_idle();

		// Random segments. Each one gets a new register setting (the first keeps
		// the reset values, then all zero, then all at maximum), one of the four
		// idle patterns, and a flight mode. The block must be idle before every write.
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == 1)
				program_regs(8'd0, 0, 0);
			else if (s == 2)
				program_regs(8'd255, 255, 255);
			else if (s > 2)
				program_regs(8'($urandom_range(0, 20)), 0, 12);
			@(posedge clk);
			src_idle_pct   = (s % 4 == 1) ? 53 : (s % 4 == 3) ? 24 : 0;
			sink_stall_pct = (s % 4 == 2) ? 53 : (s % 4 == 3) ? 24 : 0;
			queue_segment((s % 2 == 0) ? asbs_pkg::MODE_ASCENT : asbs_pkg::MODE_DESCENT);
			wait_idle();
		end

		$display("covered %0d requests and %0d results over %0d register settings",
			n_accepted, n_results, SEGMENTS);
		$display("and four idle patterns; bags finished: %0d, cut short in descent: %0d, failures: %0d",
			bag_num - asbs_pkg::FIRST_BAG, n_early_close, n_fail);
		if (n_fail == 0 && expected_status.size() == 0)
			$display("air_sample_bag_sequencer regression: pass");
		else
			$display("air_sample_bag_sequencer regression: fail");
		$finish;
	end

endmodule
